### src/ebml_element_header_parser_defines.svh
// Assertion macros shared by the EBML header parser RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH
`define EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EHP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define EHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/ebmlhp_pkg.sv
// Types and constants for the EBML element header parser.
// No dependencies.
package ebmlhp_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic        in_size_phase;
    logic [2:0]  bytes_remaining;
    logic [31:0] held_id;
    logic [3:0]  held_id_length;
    logic [55:0] size_accumulator;
    logic [3:0]  held_size_length;
  } parse_state_t;

  typedef struct packed {
    logic [31:0] element_id;
    logic [55:0] element_size;
    logic [3:0]  id_length;
    logic [3:0]  size_length;
    status_t     status;
  } result_t;

  localparam parse_state_t STATE_CLEAR = '{
    in_size_phase:    1'b0,
    bytes_remaining:  3'd0,
    held_id:          32'd0,
    held_id_length:   4'd0,
    size_accumulator: 56'd0,
    held_size_length: 4'd0
  };

endpackage

### src/ebmlhp_decode.sv
// Per-byte decode step: marker decode, shift-accumulate, result selection.
// Depends on ebmlhp_pkg.
module ebmlhp_decode (
  input  ebmlhp_pkg::parse_state_t cur,
  input  logic [7:0]               data_byte,
  input  logic                     region_end,
  output ebmlhp_pkg::parse_state_t nxt,
  output ebmlhp_pkg::result_t      res,
  output logic                     res_valid
);

  logic [3:0]              lead_len;
  logic [7:0]              size_mask;
  logic [2:0]              rem_dec;
  logic                    invalid;
  logic                    size_done;
  ebmlhp_pkg::parse_state_t step;

  always_comb begin
    if (data_byte[7]) begin
      lead_len = 4'd1;
    end else if (data_byte[7:6] == 2'b01) begin
      lead_len = 4'd2;
    end else if (data_byte[7:5] == 3'b001) begin
      lead_len = 4'd3;
    end else if (data_byte[7:4] == 4'b0001) begin
      lead_len = 4'd4;
    end else if (data_byte == 8'h01) begin
      lead_len = 4'd8;
    end else begin
      lead_len = 4'd0;
    end
  end

  always_comb begin
    case (lead_len)
      4'd1:    size_mask = 8'h7F;
      4'd2:    size_mask = 8'h3F;
      4'd3:    size_mask = 8'h1F;
      4'd4:    size_mask = 8'h0F;
      default: size_mask = 8'h00;
    endcase
  end

  assign rem_dec = cur.bytes_remaining - 3'd1;

  always_comb begin
    step      = cur;
    invalid   = 1'b0;
    size_done = 1'b0;
    if (cur.bytes_remaining == 3'd0) begin
      if (lead_len == 4'd0) begin
        invalid = 1'b1;
      end else if (!cur.in_size_phase) begin
        step.held_id         = {24'd0, data_byte};
        step.held_id_length  = lead_len;
        step.bytes_remaining = lead_len[2:0] - 3'd1;
        if (lead_len == 4'd1) begin
          step.in_size_phase = 1'b1;
        end
      end else begin
        step.size_accumulator = {48'd0, data_byte & size_mask};
        step.held_size_length = lead_len;
        step.bytes_remaining  = lead_len[2:0] - 3'd1;
        size_done             = (lead_len == 4'd1);
      end
    end else begin
      step.bytes_remaining = rem_dec;
      if (!cur.in_size_phase) begin
        step.held_id = {cur.held_id[23:0], data_byte};
        if (rem_dec == 3'd0) begin
          step.in_size_phase = 1'b1;
        end
      end else begin
        step.size_accumulator = {cur.size_accumulator[47:0], data_byte};
        size_done             = (rem_dec == 3'd0);
      end
    end
  end

  always_comb begin
    nxt       = step;
    res       = '0;
    res_valid = 1'b1;
    if (invalid) begin
      nxt        = ebmlhp_pkg::STATE_CLEAR;
      res.status = ebmlhp_pkg::STATUS_INVALID;
    end else if (size_done) begin
      nxt              = ebmlhp_pkg::STATE_CLEAR;
      res.element_id   = step.held_id;
      res.element_size = step.size_accumulator;
      res.id_length    = step.held_id_length;
      res.size_length  = step.held_size_length;
      res.status       = ebmlhp_pkg::STATUS_OK;
    end else if (region_end) begin
      nxt        = ebmlhp_pkg::STATE_CLEAR;
      res.status = ebmlhp_pkg::STATUS_TRUNCATED;
    end else begin
      res_valid = 1'b0;
    end
  end

endmodule

### src/ebml_element_header_parser.sv
// Latency: a result appears in the output register in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while data_stall is low; the single decode step and one result register set it.
// Bytes that give no result are taken even while a result waits downstream.
// Reset (rst, synchronous, active high) clears the parse state and the result valid.
// Top level of the EBML element header parser; depends on ebmlhp_pkg,
// ebmlhp_decode and ebml_element_header_parser_defines.svh.
`include "ebml_element_header_parser_defines.svh"

module ebml_element_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        region_end,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] element_id,
  output logic [55:0] element_size,
  output logic [3:0]  id_length,
  output logic [3:0]  size_length,
  output logic [1:0]  status
);

  ebmlhp_pkg::parse_state_t state;
  ebmlhp_pkg::parse_state_t state_next;
  ebmlhp_pkg::result_t      dec_res;
  ebmlhp_pkg::result_t      result;
  logic                     dec_res_valid;
  logic                     accept;

  ebmlhp_decode u_decode (
    .cur        (state),
    .data_byte  (data_byte),
    .region_end (region_end),
    .nxt        (state_next),
    .res        (dec_res),
    .res_valid  (dec_res_valid)
  );

  assign data_stall = result_valid && result_stall && dec_res_valid;
  assign accept     = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ebmlhp_pkg::STATE_CLEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && dec_res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec_res_valid) begin
      result <= dec_res;
    end
  end

  assign element_id   = result.element_id;
  assign element_size = result.element_size;
  assign id_length    = result.id_length;
  assign size_length  = result.size_length;
  assign status       = result.status;

  `EHP_ASSERT_IMPLY(a_no_overwrite,
    result_valid && result_stall,
    !(accept && dec_res_valid))
  `EHP_ASSERT_IMPLY(a_ok_lengths,
    result_valid && result.status == ebmlhp_pkg::STATUS_OK,
    id_length != 4'd0 && size_length != 4'd0)
  `EHP_ASSERT_IMPLY(a_err_zero,
    result_valid && result.status != ebmlhp_pkg::STATUS_OK,
    element_id == 32'd0 && element_size == 56'd0 && id_length == 4'd0)
  `EHP_ASSERT_NEXT(a_clear_after_result,
    accept && dec_res_valid,
    !state.in_size_phase && state.bytes_remaining == 3'd0)

endmodule
